// File: rtl/core/tqle_pkg.sv
package tqle_pkg;

  localparam int STATE_COUNT_DEF  = 64;
  localparam int ACTION_COUNT_DEF = 5;

  localparam int STATE_W   = 6;
  localparam int ACTION_W  = 3;
  localparam int VALUE_W   = 32;
  localparam int FRAC_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int S_TDATA_W = 72;
  localparam int M_TDATA_W = 8;

  localparam logic [FRAC_W-1:0] LEARN_RATE_RST   = 16'd6554;
  localparam logic [FRAC_W-1:0] DISCOUNT_RST     = 16'd58982;
  localparam logic [FRAC_W-1:0] EXPLORE_RATE_RST = 16'd6554;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPLORE_RATE = 2'd2;

  // operation codes carried in the input tuser
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_CHOOSE = 1'b1;

  typedef struct packed {
    logic load_item;
    logic clear_wr;
    logic rd_old;
    logic rd_row;
    logic mul_disc;
    logic add_tgt;
    logic mul_mix;
    logic sum_acc;
    logic wr_new;
    logic load_out;
  } tqle_cmd_t;

  typedef struct packed {
    logic is_choose;
    logic upd_ok;
    logic row_ok;
    logic exploit;
    logic col_last;
    logic clr_last;
    logic out_free;
  } tqle_status_t;

endpackage

// File: rtl/core/tabular_q_learning_engine.sv
// Channel  | Dir | Beat contents
// s_axis   | in  | tdata: chosen_action, prior_state, next_state, reward,
//          |     |   explore_sample, random_action; tuser: operation
// m_axis   | out | tdata: action_out; tuser: explored
// cfg      | in  | cfg_we, cfg_index, cfg_wdata (16-bit fraction registers)
//
// Between accepted beats an update reads its old value, scans the next_state
// row through the single read port of the table, then multiplies, adds, mixes,
// sums and writes back; a choose scans that row only when exploiting with
// next_state in range, and an ignored update returns to idle. After reset a
// clearing pass zeroes the table with s_axis_tready low; cfg writes are taken.
// A result waits in the output register; the next beat is still accepted and
// only a later choose holds in delivery until that result is taken.
module tabular_q_learning_engine
  import tqle_pkg::*;
#(
  parameter int STATE_COUNT  = STATE_COUNT_DEF,
  parameter int ACTION_COUNT = ACTION_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // chosen_action[2:0], prior_state[8:3], next_state[14:9], reward[46:15],
  // explore_sample[62:47], random_action[65:63], zero fill above
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  input  logic [0:0]           s_axis_tuser,   // operation[0]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,   // action_out[2:0], zero fill above
  output logic [0:0]           m_axis_tuser,   // explored[0]
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FRAC_W-1:0]    cfg_wdata
);

  tqle_cmd_t           cmd;
  tqle_status_t        status;
  logic [ACTION_W-1:0] action_out;
  logic                explored;

  tqle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .cmd      (cmd),
    .status   (status)
  );

  tqle_datapath #(
    .STATE_COUNT  (STATE_COUNT),
    .ACTION_COUNT (ACTION_COUNT)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .operation      (s_axis_tuser[0]),
    .chosen_action  (s_axis_tdata[2:0]),
    .prior_state    (s_axis_tdata[8:3]),
    .next_state     (s_axis_tdata[14:9]),
    .reward         (s_axis_tdata[46:15]),
    .explore_sample (s_axis_tdata[62:47]),
    .random_action  (s_axis_tdata[65:63]),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .action_out     (action_out),
    .explored       (explored)
  );

  assign m_axis_tdata = {{(M_TDATA_W - ACTION_W){1'b0}}, action_out};
  assign m_axis_tuser = explored;

  // no beat is taken while the clearing pass runs
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_wr |-> !s_axis_tready)
    else $error("input accepted during table clear");

  // a new result never overwrites one that has not been taken
  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!m_axis_tvalid || m_axis_tready))
    else $error("pending result overwritten");

  // the table write of an update never shares a cycle with a read or a clear
  a_write_alone: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_new |-> !(cmd.rd_old || cmd.rd_row || cmd.clear_wr))
    else $error("table port conflict");

  // one item at a time: busy in the cycle after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second beat accepted while busy");

endmodule

// File: rtl/core/tqle_ctrl.sv
module tqle_ctrl
  import tqle_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output tqle_cmd_t    cmd,
  input  tqle_status_t status
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN,
    ST_SCAN_END,
    ST_MUL_DISC,
    ST_ADD_TGT,
    ST_MUL_MIX,
    ST_SUM,
    ST_WRITE,
    ST_DELIVER
  } state_t;

  state_t state;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd = '0;
    case (state)
      ST_CLEAR:    cmd.clear_wr  = 1'b1;
      ST_IDLE:     cmd.load_item = in_valid;
      ST_DECIDE:   cmd.rd_old    = !status.is_choose && status.upd_ok;
      ST_SCAN:     cmd.rd_row    = 1'b1;
      ST_MUL_DISC: cmd.mul_disc  = 1'b1;
      ST_ADD_TGT:  cmd.add_tgt   = 1'b1;
      ST_MUL_MIX:  cmd.mul_mix   = 1'b1;
      ST_SUM:      cmd.sum_acc   = 1'b1;
      ST_WRITE:    cmd.wr_new    = 1'b1;
      ST_DELIVER:  cmd.load_out  = status.out_free;
      default:     cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      case (state)
        ST_CLEAR: begin
          if (status.clr_last) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid) state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (status.is_choose) begin
            state <= (status.exploit && status.row_ok) ? ST_SCAN : ST_DELIVER;
          end else begin
            // drop updates that point outside the table
            state <= status.upd_ok ? ST_SCAN : ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (status.col_last) state <= ST_SCAN_END;
        end
        ST_SCAN_END: state <= status.is_choose ? ST_DELIVER : ST_MUL_DISC;
        ST_MUL_DISC: state <= ST_ADD_TGT;
        ST_ADD_TGT:  state <= ST_MUL_MIX;
        ST_MUL_MIX:  state <= ST_SUM;
        ST_SUM:      state <= ST_WRITE;
        ST_WRITE:    state <= ST_IDLE;
        ST_DELIVER: begin
          if (status.out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/tqle_datapath.sv
module tqle_datapath
  import tqle_pkg::*;
#(
  parameter int STATE_COUNT  = STATE_COUNT_DEF,
  parameter int ACTION_COUNT = ACTION_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FRAC_W-1:0]    cfg_wdata,
  input  logic                 operation,
  input  logic [ACTION_W-1:0]  chosen_action,
  input  logic [STATE_W-1:0]   prior_state,
  input  logic [STATE_W-1:0]   next_state,
  input  logic [VALUE_W-1:0]   reward,
  input  logic [FRAC_W-1:0]    explore_sample,
  input  logic [ACTION_W-1:0]  random_action,
  input  tqle_cmd_t            cmd,
  output tqle_status_t         status,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ACTION_W-1:0]  action_out,
  output logic                 explored
);

  localparam int DEPTH  = STATE_COUNT * ACTION_COUNT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int COL_W  = $clog2(ACTION_COUNT);

  // configuration registers
  logic [FRAC_W-1:0] learn_rate;
  logic [FRAC_W-1:0] discount;
  logic [FRAC_W-1:0] explore_rate;

  // captured item
  logic                       op;
  logic [ACTION_W-1:0]        act;
  logic [STATE_W-1:0]         prior;
  logic [STATE_W-1:0]         nxt;
  logic signed [VALUE_W-1:0]  reward_val;
  logic [FRAC_W-1:0]          sample;
  logic [ACTION_W-1:0]        rnd;

  // table and its ports
  logic signed [VALUE_W-1:0] table_mem [DEPTH];
  logic signed [VALUE_W-1:0] rd_data;
  logic [ADDR_W-1:0]         clr_addr;
  logic [ADDR_W-1:0]         old_addr;
  logic [ADDR_W-1:0]         row_addr;
  logic [ADDR_W-1:0]         wr_addr;
  logic [ADDR_W-1:0]         rd_addr;
  logic signed [VALUE_W-1:0] wr_data;
  logic                      mem_we;
  logic                      mem_re;

  // row scan
  logic [COL_W-1:0]          col;
  logic [COL_W-1:0]          col_d;
  logic                      rd_old_d;
  logic                      rd_row_d;
  logic signed [VALUE_W-1:0] old_val;
  logic signed [VALUE_W-1:0] max_val;
  logic [COL_W-1:0]          best;

  // update arithmetic
  logic [FRAC_W:0]           keep;
  logic signed [FRAC_W+1:0]  keep_s;
  logic signed [FRAC_W:0]    lr_s;
  logic signed [FRAC_W:0]    disc_s;
  logic signed [48:0]        prod_c;
  logic signed [48:0]        prod;
  logic signed [48:0]        prod_rnd;
  logic signed [33:0]        target;
  logic signed [49:0]        p_old_c;
  logic signed [50:0]        p_tgt_c;
  logic signed [49:0]        p_old;
  logic signed [50:0]        p_tgt;
  logic signed [51:0]        acc_c;
  logic signed [35:0]        acc_sh;
  logic signed [VALUE_W-1:0] new_val;
  logic signed [VALUE_W-1:0] new_sat;

  logic [ACTION_W-1:0]       rnd_mod;

  // configuration writes; indexes beyond the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate   <= LEARN_RATE_RST;
      discount     <= DISCOUNT_RST;
      explore_rate <= EXPLORE_RATE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LEARN_RATE:   learn_rate   <= cfg_wdata;
        CFG_DISCOUNT:     discount     <= cfg_wdata;
        CFG_EXPLORE_RATE: explore_rate <= cfg_wdata;
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op         <= operation;
      act        <= chosen_action;
      prior      <= prior_state;
      nxt        <= next_state;
      reward_val <= $signed(reward);
      sample     <= explore_sample;
      rnd        <= random_action;
    end
  end

  assign status.is_choose = (op == OP_CHOOSE);
  assign status.row_ok    = 32'(nxt) < STATE_COUNT;
  assign status.upd_ok    = status.row_ok && (32'(prior) < STATE_COUNT)
                            && (32'(act) < ACTION_COUNT);
  assign status.exploit   = sample > explore_rate;
  assign status.col_last  = (col == COL_W'(ACTION_COUNT - 1));
  assign status.clr_last  = (clr_addr == ADDR_W'(DEPTH - 1));
  assign status.out_free  = !out_valid || out_ready;

  assign old_addr = ADDR_W'(32'(prior) * ACTION_COUNT + 32'(act));
  assign row_addr = ADDR_W'(32'(nxt) * ACTION_COUNT + 32'(col));

  assign mem_we  = cmd.clear_wr || cmd.wr_new;
  assign wr_addr = cmd.clear_wr ? clr_addr : old_addr;
  assign wr_data = cmd.clear_wr ? '0 : new_val;
  assign mem_re  = cmd.rd_old || cmd.rd_row;
  assign rd_addr = cmd.rd_old ? old_addr : row_addr;

  always_ff @(posedge clk) begin
    if (mem_we) table_mem[wr_addr] <= wr_data;
    if (mem_re) rd_data <= table_mem[rd_addr];
  end

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_wr && !status.clr_last) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_old_d <= 1'b0;
      rd_row_d <= 1'b0;
    end else begin
      rd_old_d <= cmd.rd_old;
      rd_row_d <= cmd.rd_row;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      col <= '0;
    end else if (cmd.rd_row) begin
      col <= col + 1'b1;
    end
    col_d <= col;
    if (rd_old_d) old_val <= rd_data;
    // keep the first maximum: replace only on strictly greater
    if (rd_row_d && ((col_d == '0) || (rd_data > max_val))) begin
      max_val <= rd_data;
      best    <= col_d;
    end
  end

  assign keep    = 17'h10000 - {1'b0, learn_rate};
  assign keep_s  = $signed({1'b0, keep});
  assign lr_s    = $signed({1'b0, learn_rate});
  assign disc_s  = $signed({1'b0, discount});

  assign prod_c   = disc_s * max_val;
  assign prod_rnd = prod + 49'sd32768;
  assign p_old_c  = keep_s * old_val;
  assign p_tgt_c  = lr_s * target;
  assign acc_c    = 52'(p_old) + 52'(p_tgt) + 52'sd32768;
  assign acc_sh   = $signed(acc_c[51:16]);

  always_comb begin
    if (acc_sh > 36'sd2147483647) begin
      new_sat = 32'sh7fffffff;
    end else if (acc_sh < -36'sd2147483648) begin
      new_sat = $signed(32'h80000000);
    end else begin
      new_sat = $signed(acc_sh[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_disc) prod <= prod_c;
    if (cmd.add_tgt) target <= 34'(reward_val) + 34'($signed(prod_rnd[48:16]));
    if (cmd.mul_mix) begin
      p_old <= p_old_c;
      p_tgt <= p_tgt_c;
    end
    if (cmd.sum_acc) new_val <= new_sat;
  end

  // reduce the random action into range by repeated subtraction
  always_comb begin
    rnd_mod = rnd;
    for (int i = 0; i < 4; i++) begin
      if (32'(rnd_mod) >= ACTION_COUNT) rnd_mod = rnd_mod - ACTION_W'(ACTION_COUNT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (status.exploit) begin
        action_out <= status.row_ok ? ACTION_W'(best) : '0;
      end else begin
        action_out <= rnd_mod;
      end
      explored <= !status.exploit;
    end
  end

endmodule
